@@ hdl/lafir_pkg.sv @@
// Package for the LMS adaptive FIR core: request payload types and fixed-point constants.
// No dependencies; every other file imports it.
package lafir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 32;
    localparam int STEP_W    = 16;
    localparam int MUL_A_W   = WEIGHT_W + 1;
    localparam int PROD_W    = MUL_A_W + SAMPLE_W;
    localparam int Y_SHIFT   = 28;
    localparam int UPD_SHIFT = 17;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic signed [SAMPLE_W-1:0] desired;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filter_out;
        logic signed [SAMPLE_W-1:0] error_out;
    } out_item_t;

endpackage

@@ hdl/lms_adaptive_fir_core.sv @@
// Top level of the LMS adaptive FIR core: sequencer, tap memories and one shared multiplier.
// Depends on lafir_pkg for payload types and fixed-point constants.
//
// Channel    Direction  Handshake              Content
// in         request    in_valid / in_ready    sample_in, desired (Q1.15)
// out        result     out_valid / out_ready  filter_out, error_out (Q1.15)
// cfg        write      cfg_wr_en              step_size (Q0.16)
//
// Each request passes through the single multiplier, which
// runs one tap per cycle through the dot product and again through the weight update.
// Reset clears the sequencer and the valid bits of both tap memories and sets the step size
// to STEP_RESET, so the delay line and the weights read as zero until written.
// The finished result waits in an output register; a stalled output holds the following
// request only in its final state, S_FIN.
module lms_adaptive_fir_core
    import lafir_pkg::*;
#(
    parameter int TAPS = 21
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_wr_en,
    input  logic [STEP_W-1:0]   cfg_wr_data
);

    localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW   = $clog2(TAPS + 1) > 0 ? $clog2(TAPS + 1) : 1;
    localparam int ACCW = PROD_W + CW;
    localparam int YW   = ACCW - Y_SHIFT;
    localparam int TW   = PROD_W - UPD_SHIFT;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_ERR  = 6'b000100,
        S_STEP = 6'b001000,
        S_UPD  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]            step_reg;
    logic [AW-1:0]                head_reg;
    logic [AW-1:0]                head_new;
    logic [AW-1:0]                rp_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         issue;
    logic                         issue_last;

    logic                         p1_reg, p2_reg;
    logic                         last1_reg, last2_reg;
    logic [AW-1:0]                idx1_reg, idx2_reg;

    logic signed [SAMPLE_W-1:0]   x_mem [TAPS];
    logic signed [WEIGHT_W-1:0]   w_mem [TAPS];
    logic [TAPS-1:0]              x_vld_reg;
    logic [TAPS-1:0]              w_vld_reg;
    logic signed [SAMPLE_W-1:0]   x_rd_reg;
    logic signed [WEIGHT_W-1:0]   w_rd_reg;
    logic signed [WEIGHT_W-1:0]   w_d2_reg;

    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [SAMPLE_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [MUL_A_W-1:0]    se_reg;
    logic signed [ACCW-1:0]       acc_reg;

    logic signed [SAMPLE_W-1:0]   desired_reg;
    logic signed [SAMPLE_W-1:0]   y_reg;
    logic signed [SAMPLE_W-1:0]   e_reg;

    logic signed [ACCW-1:0]       acc_rnd;
    logic signed [YW:0]           y_ext;
    logic signed [YW:0]           diff;
    logic signed [PROD_W-1:0]     prod_rnd;
    logic signed [TW-1:0]         term;
    logic signed [WEIGHT_W:0]     wsum;
    logic signed [WEIGHT_W-1:0]   w_new;
    logic                         w_we;
    logic                         accept;
    logic                         out_load;
    logic                         out_valid_reg;
    out_item_t                    out_data_reg;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [YW:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v[YW:SAMPLE_W-1] != {(YW - SAMPLE_W + 2){v[YW]}})
        begin
            r = v[YW] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_load   = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign issue      = ((state_reg == S_MAC) || (state_reg == S_UPD)) && (cnt_reg != CW'(TAPS));
    assign issue_last = (cnt_reg == CW'(TAPS - 1));
    assign head_new   = (head_reg == '0) ? AW'(TAPS - 1) : head_reg - AW'(1);

    always_comb
    begin
        mul_a = {{(MUL_A_W-WEIGHT_W){w_rd_reg[WEIGHT_W-1]}}, w_rd_reg};
        mul_b = x_rd_reg;
        if (state_reg == S_STEP)
        begin
            mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step_reg};
            mul_b = e_reg;
        end
        else if (state_reg == S_UPD)
        begin
            mul_a = se_reg;
        end
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        acc_rnd  = acc_reg + (ACCW'(1) <<< (Y_SHIFT - 1));
        y_ext    = {acc_rnd[ACCW-1], acc_rnd[ACCW-1:Y_SHIFT]};
        diff     = {{(YW-SAMPLE_W+1){desired_reg[SAMPLE_W-1]}}, desired_reg} - y_ext;
        prod_rnd = prod_reg + (PROD_W'(1) <<< (UPD_SHIFT - 1));
        term     = prod_rnd[PROD_W-1:UPD_SHIFT];
        wsum     = {w_d2_reg[WEIGHT_W-1], w_d2_reg} + {term[TW-1], term};
        if (wsum[WEIGHT_W] != wsum[WEIGHT_W-1])
        begin
            w_new = wsum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                   : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
        else
        begin
            w_new = wsum[WEIGHT_W-1:0];
        end
        w_we = (state_reg == S_UPD) && p2_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (p2_reg && last2_reg)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (p2_reg && last2_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_RESET;
            head_reg      <= '0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            x_vld_reg     <= '0;
            w_vld_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end
            p1_reg <= issue;
            p2_reg <= p1_reg;
            if (accept)
            begin
                head_reg            <= head_new;
                rp_reg              <= head_new;
                cnt_reg             <= '0;
                x_vld_reg[head_new] <= 1'b1;
            end
            else if (state_reg == S_STEP)
            begin
                rp_reg  <= head_reg;
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                rp_reg  <= (rp_reg == AW'(TAPS - 1)) ? '0 : rp_reg + AW'(1);
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (w_we)
            begin
                w_vld_reg[idx2_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_mem[head_new] <= in_data.sample_in;
        end
        if (w_we)
        begin
            w_mem[idx2_reg] <= w_new;
        end
        x_rd_reg  <= x_vld_reg[rp_reg] ? x_mem[rp_reg] : '0;
        w_rd_reg  <= w_vld_reg[cnt_reg[AW-1:0]] ? w_mem[cnt_reg[AW-1:0]] : '0;
        w_d2_reg  <= w_rd_reg;
        idx1_reg  <= cnt_reg[AW-1:0];
        idx2_reg  <= idx1_reg;
        last1_reg <= issue_last;
        last2_reg <= last1_reg;
        if (p1_reg)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_STEP)
        begin
            se_reg <= mul_p[MUL_A_W-1:0];
        end
        if (accept)
        begin
            desired_reg <= in_data.desired;
            acc_reg     <= '0;
        end
        else if ((state_reg == S_MAC) && p2_reg)
        begin
            acc_reg <= acc_reg + {{(ACCW-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (state_reg == S_ERR)
        begin
            y_reg <= sat16(y_ext);
            e_reg <= sat16(diff);
        end
        if (out_load)
        begin
            out_data_reg.filter_out <= y_reg;
            out_data_reg.error_out  <= e_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TAPS))
        else $error("Tap counter ran past the tap count.");

    a_err_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR) |-> (!p1_reg && !p2_reg))
        else $error("Error stage entered with products still in flight.");

    a_wr_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_reg && (state_reg != S_UPD)) |-> (state_reg == S_MAC))
        else $error("Pipeline active outside the dot product and update phases.");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MAC) && (cnt_reg == '0))
        else $error("Accepted request did not start the dot product.");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("Finished result was not presented.");

endmodule

@@ dv/lms_adaptive_fir_core_test.sv @@
// Self-checking testbench for lms_adaptive_fir_core: directed and random requests under
// several step sizes, checked against a cycle-free LMS predictor kept in a scoreboard class.
// Depends on lafir_pkg and hdl/lms_adaptive_fir_core.sv; needs nothing else to run.
`timescale 1ns / 100ps

module lms_adaptive_fir_core_test;
    import lafir_pkg::*;

    localparam int TAPS = 21;
    localparam int SETTLE_CYCLES = 2 * TAPS + 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam longint SAMPLE_MAX = 32767;
    localparam longint SAMPLE_MIN = -32768;
    localparam longint WEIGHT_MAX = 64'sd2147483647;
    localparam longint WEIGHT_MIN = -WEIGHT_MAX - 1;

    typedef enum int {
        MODE_FULL,
        MODE_SMALL,
        MODE_EDGE,
        MODE_PLANT
    } stim_mode_t;

    class lms_scoreboard;
        logic signed [SAMPLE_W-1:0] delay_taps [TAPS];
        logic signed [WEIGHT_W-1:0] coefs [TAPS];
        logic [STEP_W-1:0] beta;
        out_item_t pending_outputs [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned out_clamps;
        int unsigned err_clamps;
        int unsigned coef_clamps;

        function new();
            foreach (delay_taps[i])
            begin
                delay_taps[i] = '0;
                coefs[i] = '0;
            end
            beta = STEP_RESET;
            mismatches = 0;
            checked = 0;
            out_clamps = 0;
            err_clamps = 0;
            coef_clamps = 0;
        endfunction

        function void set_step(input logic [STEP_W-1:0] value);
            beta = value;
        endfunction

        function int outstanding();
            return pending_outputs.size();
        endfunction

        function void note_request(input in_item_t item);
            longint acc;
            longint y;
            longint e;
            longint term;
            longint sum;
            longint step;
            out_item_t predicted;
            int i;
            for (i = TAPS - 1; i > 0; i--)
                delay_taps[i] = delay_taps[i - 1];
            delay_taps[0] = item.sample_in;
            acc = 0;
            for (i = 0; i < TAPS; i++)
                acc += longint'(coefs[i]) * longint'(delay_taps[i]);
            y = (acc + (longint'(1) << (Y_SHIFT - 1))) >>> Y_SHIFT;
            e = longint'(item.desired) - y;
            if (e > SAMPLE_MAX || e < SAMPLE_MIN)
                err_clamps++;
            e = (e > SAMPLE_MAX) ? SAMPLE_MAX : (e < SAMPLE_MIN) ? SAMPLE_MIN : e;
            if (y > SAMPLE_MAX || y < SAMPLE_MIN)
                out_clamps++;
            y = (y > SAMPLE_MAX) ? SAMPLE_MAX : (y < SAMPLE_MIN) ? SAMPLE_MIN : y;
            step = longint'(beta);
            for (i = 0; i < TAPS; i++)
            begin
                term = step * e * longint'(delay_taps[i]);
                term = (term + (longint'(1) << (UPD_SHIFT - 1))) >>> UPD_SHIFT;
                sum = longint'(coefs[i]) + term;
                if (sum > WEIGHT_MAX || sum < WEIGHT_MIN)
                    coef_clamps++;
                sum = (sum > WEIGHT_MAX) ? WEIGHT_MAX : (sum < WEIGHT_MIN) ? WEIGHT_MIN : sum;
                coefs[i] = sum[WEIGHT_W-1:0];
            end
            predicted.filter_out = y[SAMPLE_W-1:0];
            predicted.error_out = e[SAMPLE_W-1:0];
            pending_outputs.push_back(predicted);
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (pending_outputs.size() == 0)
            begin
                $error("result with no request pending: filter_out %0d, error_out %0d",
                       got.filter_out, got.error_out);
                mismatches++;
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            if (got.filter_out !== want.filter_out)
            begin
                $error("filter_out: expected %0d, actual %0d", want.filter_out, got.filter_out);
                mismatches++;
            end
            if (got.error_out !== want.error_out)
            begin
                $error("error_out: expected %0d, actual %0d", want.error_out, got.error_out);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [STEP_W-1:0] cfg_wr_data = '0;

    lms_scoreboard board;
    bit no_gaps = 1'b0;
    int unsigned cycles = 0;
    int unsigned sent = 0;
    int unsigned step_writes = 0;
    logic signed [SAMPLE_W-1:0] plant_x = '0;

    lms_adaptive_fir_core #(
        .TAPS(TAPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
        out_ready <= no_gaps || ($urandom_range(99) >= 17);
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("lms_adaptive_fir_core_test NOT OK");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_value(input stim_mode_t mode);
        logic [SAMPLE_W-1:0] r;
        case (mode)
            MODE_SMALL: r = SAMPLE_W'($urandom_range(2047)) - 16'd1024;
            MODE_EDGE:
            begin
                case ($urandom_range(3))
                    0: r = 16'h8000;
                    1: r = 16'h7FFF;
                    2: r = 16'h0000;
                    default: r = 16'hFFFF;
                endcase
            end
            default: r = SAMPLE_W'($urandom);
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] d);
        in_item_t item;
        item.sample_in = x;
        item.desired = d;
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(item);
        sent++;
        if (!no_gaps && $urandom_range(99) < 17)
        begin
            // Hold off until the block is ready again so that the pause shows at the port.
            in_valid <= 1'b0;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        drain_and_settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_step(value);
        step_writes++;
    endtask

    task automatic run_random(input int count);
        stim_mode_t mode;
        int left_in_burst;
        int n;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] d;
        mode = MODE_FULL;
        left_in_burst = 0;
        for (n = 0; n < count; n++)
        begin
            if (left_in_burst == 0)
            begin
                mode = stim_mode_t'($urandom_range(3));
                left_in_burst = $urandom_range(8, 40);
            end
            left_in_burst--;
            if (mode == MODE_PLANT)
            begin
                // A small fixed two-tap system that the filter can learn to match.
                x = pick_value(MODE_FULL) >>> 2;
                d = (plant_x >>> 1) + (x >>> 2);
                plant_x = x;
            end
            else
            begin
                x = pick_value(mode);
                d = pick_value(mode);
            end
            send_request(x, d);
            if ($urandom_range(199) == 0)
                drain_and_settle();
        end
    endtask

    initial
    begin
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(16'sh0000, 16'sh0000);
        send_request(16'sh7FFF, 16'sh7FFF);
        send_request(16'sh8000, 16'sh8000);
        send_request(16'sh7FFF, 16'sh8000);
        send_request(16'sh8000, 16'sh7FFF);
        send_request(16'sh0001, 16'shFFFF);
        send_request(16'shFFFF, 16'sh0001);
        send_request(16'sh5555, 16'shAAAA);
        send_request(16'shAAAA, 16'sh5555);
        send_request(16'sh0000, 16'sh7FFF);
        send_request(16'sh0000, 16'sh8000);

        write_step(16'hFFFF);
        repeat (3) send_request(16'sh7FFF, 16'sh7FFF);
        repeat (3) send_request(16'sh8000, 16'sh7FFF);
        repeat (2) send_request(16'sh7FFF, 16'sh8000);
        run_random(400);

        write_step(16'h0000);
        run_random(200);

        write_step(16'h0001);
        run_random(250);

        write_step(STEP_W'($urandom_range(2, 65534)));
        no_gaps = 1'b1;
        run_random(300);
        no_gaps = 1'b0;

        write_step(STEP_RESET);
        run_random(400);

        write_step(16'h4000);
        run_random(400);

        drain_and_settle();
        $display("Sent %0d requests across %0d step-size writes; %0d results checked.",
                 sent, step_writes, board.checked);
        $display("Clamping seen: output %0d, error %0d, weight %0d times; %0d mismatches.",
                 board.out_clamps, board.err_clamps, board.coef_clamps, board.mismatches);
        if (board.mismatches == 0)
            $display("lms_adaptive_fir_core_test OK");
        else
            $display("lms_adaptive_fir_core_test NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lafir_pkg.sv
hdl/lms_adaptive_fir_core.sv
dv/lms_adaptive_fir_core_test.sv
